// ===== hw/rtl/bgi_pkg.sv =====
// Package for the bilinear grid interpolator.
// Holds widths, fixed-point constants, request and register codes.
// No dependencies.
package bgi_pkg;

	localparam int FRAC_BITS = 8;
	localparam int MAX_SIDE  = 256;

	localparam int SIDE_W   = 9;
	localparam int POS_W    = 17;
	localparam int INT_W    = POS_W - FRAC_BITS;
	localparam int SAMPLE_W = 16;
	localparam int ADDR_W   = 16;
	localparam int VALUE_W  = 32;

	localparam int BASE_SUM_W = SIDE_W + INT_W + 1;

	localparam int BANK_AW    = ADDR_W - 1;
	localparam int BANK_DEPTH = 2 ** BANK_AW;
	localparam int NUM_BANKS  = 4;

	localparam int WGT_W    = 2 * FRAC_BITS + 1;
	localparam int PROD_W   = SAMPLE_W + WGT_W + 1;
	localparam int ACC_W    = PROD_W + 2;
	localparam int SHR      = (2 * FRAC_BITS > 16) ? 2 * FRAC_BITS - 16 : 0;
	localparam int SHL      = (2 * FRAC_BITS < 16) ? 16 - 2 * FRAC_BITS : 0;
	localparam int SCALED_W = ACC_W + SHL;
	localparam int CMP_W    = SIDE_W + FRAC_BITS + POS_W;

	localparam logic [FRAC_BITS:0] ONE = (FRAC_BITS + 1)'(1) << FRAC_BITS;

	typedef enum logic {
		OP_LOAD  = 1'b0,
		OP_QUERY = 1'b1
	} op_t;

	typedef enum logic {
		REG_GRID_COLS = 1'b0,
		REG_GRID_ROWS = 1'b1
	} reg_index_t;

	typedef logic [SIDE_W-1:0] side_t;

endpackage

// ===== hw/rtl/bgi_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module bgi_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== hw/rtl/bilinear_grid_interpolator.sv =====
// Bilinear grid interpolator: grid store in four RAM banks and a blending pipeline.
// Depends on bgi_pkg and bgi_ram.
// Accepts one request per cycle while in_stall is low.
// Loads give no result; a query accepted in the next cycle already sees the new sample.
// The 2x2 neighborhood comes from two copies of the grid, each split into even and odd
// address banks, so all four neighbors are read in the same cycle. Reset clears the
// pipeline and sets both grid sizes to 256; grid contents are undefined until loaded.
module bilinear_grid_interpolator (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic                                cfg_index,
	input  logic [bgi_pkg::SIDE_W-1:0]          cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                op,
	input  logic signed [bgi_pkg::SAMPLE_W-1:0] sample,
	input  logic [bgi_pkg::ADDR_W-1:0]          cell_index,
	input  logic [bgi_pkg::POS_W-1:0]           x_pos,
	input  logic [bgi_pkg::POS_W-1:0]           y_pos,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [bgi_pkg::VALUE_W-1:0]  value,
	output logic                                out_of_range
);

	localparam int FB  = bgi_pkg::FRAC_BITS;
	localparam int AW  = bgi_pkg::ADDR_W;
	localparam int SW  = bgi_pkg::SIDE_W;
	localparam int IW  = bgi_pkg::INT_W;
	localparam int BW  = bgi_pkg::BASE_SUM_W;

	logic adv;

	bgi_pkg::side_t cols_q, rows_q, cfg_clamped;

	always_comb begin
		if (cfg_data == '0) begin
			cfg_clamped = SW'(1);
		end else if (cfg_data > SW'(bgi_pkg::MAX_SIDE)) begin
			cfg_clamped = SW'(bgi_pkg::MAX_SIDE);
		end else begin
			cfg_clamped = cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q <= SW'(bgi_pkg::MAX_SIDE);
			rows_q <= SW'(bgi_pkg::MAX_SIDE);
		end else if (cfg_wr_en) begin
			unique case (bgi_pkg::reg_index_t'(cfg_index))
				bgi_pkg::REG_GRID_COLS: cols_q <= cfg_clamped;
				bgi_pkg::REG_GRID_ROWS: rows_q <= cfg_clamped;
				default: ;
			endcase
		end
	end

	// The whole pipeline moves together whenever the output register can take a result.
	assign adv      = !out_valid || !out_stall;
	assign in_stall = !adv;

	// Stage 1: captured request, range check and row-major base address.
	logic                         valid_s1;
	bgi_pkg::op_t                 op_s1;
	logic signed [bgi_pkg::SAMPLE_W-1:0] sample_s1;
	logic [AW-1:0]                index_s1;
	logic [bgi_pkg::POS_W-1:0]    x_s1, y_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && in_valid) begin
			op_s1     <= bgi_pkg::op_t'(op);
			sample_s1 <= sample;
			index_s1  <= cell_index;
			x_s1      <= x_pos;
			y_s1      <= y_pos;
		end
	end

	logic          oor_c;
	logic [IW-1:0] col_off, row_off;
	logic [BW-1:0] base_full;

	always_comb begin
		oor_c = (x_s1 < bgi_pkg::POS_W'(bgi_pkg::ONE))
			|| (bgi_pkg::CMP_W'(x_s1) > bgi_pkg::CMP_W'({cols_q, {FB{1'b0}}}))
			|| (y_s1 < bgi_pkg::POS_W'(bgi_pkg::ONE))
			|| (bgi_pkg::CMP_W'(y_s1) > bgi_pkg::CMP_W'({rows_q, {FB{1'b0}}}));
		col_off   = x_s1[bgi_pkg::POS_W-1:FB] - IW'(1);
		row_off   = y_s1[bgi_pkg::POS_W-1:FB] - IW'(1);
		base_full = BW'(row_off) * BW'(cols_q) + BW'(col_off);
	end

	// Stage 2: RAM access and weight products.
	logic                         valid_s2, oor_s2;
	bgi_pkg::op_t                 op_s2;
	logic signed [bgi_pkg::SAMPLE_W-1:0] sample_s2;
	logic [AW-1:0]                index_s2, base_s2;
	logic [FB-1:0]                s_s2, t_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s2     <= op_s1;
			sample_s2 <= sample_s1;
			index_s2  <= index_s1;
			base_s2   <= base_full[AW-1:0];
			s_s2      <= x_s1[FB-1:0];
			t_s2      <= y_s1[FB-1:0];
			oor_s2    <= oor_c;
		end
	end

	logic [AW-1:0]               a_right, a_down, a_diag;
	logic [FB:0]                 om_s, om_t;
	logic [bgi_pkg::WGT_W-1:0]   w00_c, w01_c, w10_c, w11_c;
	logic [bgi_pkg::BANK_AW-1:0] raddr [bgi_pkg::NUM_BANKS];
	logic [bgi_pkg::SAMPLE_W-1:0] rdata [bgi_pkg::NUM_BANKS];
	logic                        load_s2;

	always_comb begin
		a_right = base_s2 + AW'(1);
		a_down  = base_s2 + AW'(cols_q);
		a_diag  = a_down + AW'(1);
		om_s    = bgi_pkg::ONE - (FB + 1)'(s_s2);
		om_t    = bgi_pkg::ONE - (FB + 1)'(t_s2);
		w00_c   = bgi_pkg::WGT_W'(om_s) * bgi_pkg::WGT_W'(om_t);
		w01_c   = bgi_pkg::WGT_W'(s_s2) * bgi_pkg::WGT_W'(om_t);
		w10_c   = bgi_pkg::WGT_W'(om_s) * bgi_pkg::WGT_W'(t_s2);
		w11_c   = bgi_pkg::WGT_W'(s_s2) * bgi_pkg::WGT_W'(t_s2);
		raddr[0] = base_s2[0] ? a_right[AW-1:1] : base_s2[AW-1:1];
		raddr[1] = base_s2[AW-1:1];
		raddr[2] = a_down[0] ? a_diag[AW-1:1] : a_down[AW-1:1];
		raddr[3] = a_down[AW-1:1];
		load_s2  = adv && valid_s2 && (op_s2 == bgi_pkg::OP_LOAD);
	end

	// Banks 0 and 1 hold the even and odd entries of the upper-row copy,
	// banks 2 and 3 those of the lower-row copy.
	for (genvar k = 0; k < bgi_pkg::NUM_BANKS; k++) begin : g_bank
		bgi_ram #(
			.WIDTH(bgi_pkg::SAMPLE_W),
			.DEPTH(bgi_pkg::BANK_DEPTH)
		) u_ram (
			.clk    (clk),
			.wr_en  (load_s2 && (index_s2[0] == 1'(k % 2))),
			.wr_addr(index_s2[AW-1:1]),
			.wr_data(sample_s2),
			.rd_en  (adv),
			.rd_addr(raddr[k]),
			.rd_data(rdata[k])
		);
	end

	// Stage 3: neighbor selection and sample-times-weight products.
	logic                      valid_s3, oor_s3, swap_a_s3, swap_b_s3, s_nz_s3, t_nz_s3;
	logic [bgi_pkg::WGT_W-1:0] w00_s3, w01_s3, w10_s3, w11_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s3 <= valid_s2 && (op_s2 == bgi_pkg::OP_QUERY);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			oor_s3    <= oor_s2;
			swap_a_s3 <= base_s2[0];
			swap_b_s3 <= a_down[0];
			s_nz_s3   <= (s_s2 != '0);
			t_nz_s3   <= (t_s2 != '0);
			w00_s3    <= w00_c;
			w01_s3    <= w01_c;
			w10_s3    <= w10_c;
			w11_s3    <= w11_c;
		end
	end

	logic signed [bgi_pkg::SAMPLE_W-1:0] d00, d01, d10, d11;
	logic signed [bgi_pkg::PROD_W-1:0]   p00_c, p01_c, p10_c, p11_c;

	always_comb begin
		d00 = swap_a_s3 ? rdata[1] : rdata[0];
		d01 = swap_a_s3 ? rdata[0] : rdata[1];
		d10 = swap_b_s3 ? rdata[3] : rdata[2];
		d11 = swap_b_s3 ? rdata[2] : rdata[3];
		if (!s_nz_s3) begin
			d01 = '0;
		end
		if (!t_nz_s3) begin
			d10 = '0;
		end
		if (!s_nz_s3 || !t_nz_s3) begin
			d11 = '0;
		end
		p00_c = d00 * $signed({1'b0, w00_s3});
		p01_c = d01 * $signed({1'b0, w01_s3});
		p10_c = d10 * $signed({1'b0, w10_s3});
		p11_c = d11 * $signed({1'b0, w11_s3});
	end

	// Stage 4: sum of the four products.
	logic                              valid_s4, oor_s4;
	logic signed [bgi_pkg::PROD_W-1:0] p00_s4, p01_s4, p10_s4, p11_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (adv) begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			oor_s4 <= oor_s3;
			p00_s4 <= p00_c;
			p01_s4 <= p01_c;
			p10_s4 <= p10_c;
			p11_s4 <= p11_c;
		end
	end

	logic signed [bgi_pkg::ACC_W-1:0] acc_c;

	assign acc_c = bgi_pkg::ACC_W'(p00_s4) + bgi_pkg::ACC_W'(p01_s4)
		+ bgi_pkg::ACC_W'(p10_s4) + bgi_pkg::ACC_W'(p11_s4);

	// Stage 5: scaling to 16 fraction bits and saturation into the output register.
	logic                             valid_s5, oor_s5;
	logic signed [bgi_pkg::ACC_W-1:0] acc_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else if (adv) begin
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			oor_s5 <= oor_s4;
			acc_s5 <= acc_c;
		end
	end

	localparam logic signed [bgi_pkg::VALUE_W-1:0] VMAX = {1'b0, {(bgi_pkg::VALUE_W-1){1'b1}}};
	localparam logic signed [bgi_pkg::VALUE_W-1:0] VMIN = {1'b1, {(bgi_pkg::VALUE_W-1){1'b0}}};

	logic signed [bgi_pkg::SCALED_W-1:0] scaled;
	logic signed [bgi_pkg::VALUE_W-1:0]  value_c;

	always_comb begin
		scaled = (bgi_pkg::SCALED_W'(acc_s5) <<< bgi_pkg::SHL) >>> bgi_pkg::SHR;
		if (oor_s5) begin
			value_c = '0;
		end else if (scaled > bgi_pkg::SCALED_W'(VMAX)) begin
			value_c = VMAX;
		end else if (scaled < bgi_pkg::SCALED_W'(VMIN)) begin
			value_c = VMIN;
		end else begin
			value_c = scaled[bgi_pkg::VALUE_W-1:0];
		end
	end

	logic                               out_valid_q, out_of_range_q;
	logic signed [bgi_pkg::VALUE_W-1:0] value_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			value_q        <= value_c;
			out_of_range_q <= oor_s5;
		end
	end

	assign out_valid    = out_valid_q;
	assign value        = value_q;
	assign out_of_range = out_of_range_q;

endmodule
